/* sv/hsr_pkg.sv */
// ----------------------------------------------------------------------------
// hsr_pkg: shared types and codes for the resizing hash set
// Request and result payloads, operation and register codes, engine states.
// ----------------------------------------------------------------------------
package hsr_pkg;

  localparam int KEY_W   = 31;
  localparam int BIDX_W  = 12;
  localparam int COUNT_W = 11;
  localparam int TOTAL_W = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  localparam logic [1:0] FUNC_INSERT = 2'd0;
  localparam logic [1:0] FUNC_REMOVE = 2'd1;
  localparam logic [1:0] FUNC_TEST   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_GROW   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHRINK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN    = 2'd2;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    OP_INSERT,
    OP_REMOVE,
    OP_TEST
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_WRITE,
    S_FINISH
  } eng_state_t;

  typedef struct packed {
    logic [1:0]       func;
    logic [KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic               was_present;
    logic               status;
    logic [BIDX_W-1:0]  bucket_index;
    logic [COUNT_W-1:0] item_count;
    logic [TOTAL_W-1:0] bucket_total;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } req_t;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

endpackage

/* sv/hash_set_with_resizing.sv */
// ----------------------------------------------------------------------------
// hash_set_with_resizing: bounded hash set with a doubling/halving bucket count
// Queue-like request and result sides, register write port, packed key store.
// ----------------------------------------------------------------------------
// Order: the search ends once the remainder unit and the key scan are done;
//   a remove that hits then moves the last key into the hole (S_WRITE).
// Throughput: one request at a time in the engine; the rate is set by the
//   31-step remainder, the one-read-a-cycle scan and unpopped results.
// Reset: store empty, bucket count 10, registers 65 / 30 / 10, queues empty.
// ----------------------------------------------------------------------------
module hash_set_with_resizing #(
  parameter int CAPACITY    = 1024,
  parameter int MAX_BUCKETS = 4096
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  hsr_pkg::in_item_t                   request,
  output logic                                empty,
  input  logic                                pop,
  output hsr_pkg::out_item_t                  result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hsr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hsr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hsr_pkg::*;

  logic     req_valid;
  req_t     req_head;
  logic     req_take;
  logic     out_valid;
  cfg_wr_t  cfg_wr;

  // Register writes land at once; the user must send them only while the engine is idle; this is not enforced.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  // Front end: decode each request and hold it until the engine frees up.
  hsr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .request   (request),
    .req_valid (req_valid),
    .req_head  (req_head),
    .req_take  (req_take)
  );

  // Engine: search, update and resize, with a result register at its end so
  // the next request can start while the previous result waits to be popped.
  hsr_back #(
    .CAPACITY    (CAPACITY),
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_head  (req_head),
    .req_take  (req_take),
    .cfg_wr    (cfg_wr),
    .out_valid (out_valid),
    .out_item  (result),
    .out_take  (pop)
  );

  assign empty = !out_valid;

endmodule

/* sv/hsr_front.sv */
// ----------------------------------------------------------------------------
// hsr_front: request intake
// Decode the function code and hold up to two requests for the engine.
// ----------------------------------------------------------------------------
module hsr_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  hsr_pkg::in_item_t request,
  output logic            req_valid,
  output hsr_pkg::req_t   req_head,
  input  logic            req_take
);
  import hsr_pkg::*;

  req_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  req_t       decoded;
  logic       do_push;
  logic       do_pop;

  always_comb begin
    decoded.key = request.key;
    unique case (request.func)
      FUNC_INSERT: decoded.op = OP_INSERT;
      FUNC_REMOVE: decoded.op = OP_REMOVE;
      default:     decoded.op = OP_TEST;
    endcase
  end

  assign full      = (fill == 2'd2);
  assign req_valid = (fill != 2'd0);
  assign req_head  = slot[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = req_take && req_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

/* sv/hsr_mod.sv */
// ----------------------------------------------------------------------------
// hsr_mod: key modulo bucket count
// Restoring remainder, one key bit per cycle.
// ----------------------------------------------------------------------------
module hsr_mod #(
  parameter int BW = 13
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hsr_pkg::KEY_W-1:0] dividend,
  input  logic [BW-1:0]            divisor,
  output logic                     done,
  output logic [BW-1:0]            rem
);
  import hsr_pkg::*;

  localparam int SW = $clog2(KEY_W + 1);

  logic [KEY_W-1:0] shreg;
  logic [BW-1:0]    dvs;
  logic [BW:0]      part;
  logic [SW-1:0]    steps;
  logic             busy;
  logic [BW:0]      trial;

  assign trial = {rem, shreg[KEY_W-1]};

  always_comb begin
    if (trial >= {1'b0, dvs}) begin
      part = trial - {1'b0, dvs};
    end else begin
      part = trial;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy  <= 1'b1;
      done  <= 1'b0;
      steps <= SW'(KEY_W);
      shreg <= dividend;
      dvs   <= divisor;
      rem   <= '0;
    end else if (busy) begin
      rem   <= part[BW-1:0];
      shreg <= {shreg[KEY_W-2:0], 1'b0};
      steps <= steps - SW'(1);
      if (steps == SW'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

endmodule

/* sv/hsr_back.sv */
// ----------------------------------------------------------------------------
// hsr_back: set engine
// Search the packed key store, apply the operation, resize and report.
// ----------------------------------------------------------------------------
module hsr_back #(
  parameter int CAPACITY    = 1024,
  parameter int MAX_BUCKETS = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  input  hsr_pkg::req_t      req_head,
  output logic               req_take,
  input  hsr_pkg::cfg_wr_t   cfg_wr,
  output logic               out_valid,
  output hsr_pkg::out_item_t out_item,
  input  logic               out_take
);
  import hsr_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int BW = $clog2(MAX_BUCKETS + 1);
  localparam int FW = (BW > CFG_DATA_W) ? BW : CFG_DATA_W;
  localparam int PW = ((CW > BW) ? CW : BW) + 8;

  logic [KEY_W-1:0] store [CAPACITY];

  eng_state_t state, state_next;
  op_t              op;
  logic [KEY_W-1:0] key_r;
  logic [CW-1:0]    idx;
  logic             q_valid;
  logic [AW-1:0]    q_idx;
  logic [KEY_W-1:0] mem_q;
  logic             found;
  logic [AW-1:0]    pos;
  logic [CW-1:0]    count;
  logic [BW-1:0]    buckets;
  logic             added;
  logic             status;
  logic [6:0]       grow_pct;
  logic [6:0]       shrink_pct;
  logic [CFG_DATA_W-1:0] min_b;

  logic             hit, found_now, issue, search_end, finish_fire, store_full;
  logic [AW-1:0]    pos_now, rd_addr, last_addr;
  logic             mem_we;
  logic [AW-1:0]    mem_wa;
  logic [KEY_W-1:0] mem_wd;
  logic             div_done;
  logic [BW-1:0]    div_rem;
  logic [PW-1:0]    load, grow_lim, shrink_lim;
  logic             grow_ok, shrink_ok;
  logic [BW-1:0]    new_buckets;
  logic [FW-1:0]    min_floor, cfg_floor;

  function automatic logic [FW-1:0] floor_of(input logic [CFG_DATA_W-1:0] m);
    logic [FW-1:0] f;
    f = FW'(m);
    if (m == '0) begin
      f = FW'(1);
    end else if (f > FW'(MAX_BUCKETS)) begin
      f = FW'(MAX_BUCKETS);
    end
    return f;
  endfunction

  hsr_mod #(.BW(BW)) u_mod (
    .clk      (clk),
    .rst      (rst),
    .start    (req_take),
    .dividend (req_head.key),
    .divisor  (buckets),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign min_floor  = floor_of(min_b);
  assign cfg_floor  = floor_of(cfg_wr.data);
  assign store_full = (count == CW'(CAPACITY));
  assign last_addr  = AW'(count - CW'(1));

  always_comb begin
    hit       = q_valid && (mem_q == key_r);
    found_now = found || hit;
    pos_now   = hit ? q_idx : pos;
    issue     = (state == S_SEARCH) && !found_now && (idx < count);
    rd_addr   = issue ? idx[AW-1:0] : last_addr;
    req_take  = (state == S_IDLE) && req_valid;
    search_end  = (state == S_SEARCH) && !issue && div_done;
    finish_fire = (state == S_FINISH) && (!out_valid || out_take);

    mem_we = 1'b0;
    mem_wa = pos;
    mem_wd = mem_q;
    if (search_end && op == OP_INSERT && !found_now && !store_full) begin
      mem_we = 1'b1;
      mem_wa = count[AW-1:0];
      mem_wd = key_r;
    end else if (state == S_WRITE) begin
      mem_we = 1'b1;
    end

    load       = PW'(count) * PW'(100);
    grow_lim   = PW'(grow_pct) * PW'(buckets);
    shrink_lim = PW'(shrink_pct) * PW'(buckets);
    grow_ok    = added && (load > grow_lim) &&
                 (({1'b0, buckets} << 1) <= (BW + 1)'(MAX_BUCKETS));
    shrink_ok  = (op == OP_REMOVE) && (load < shrink_lim) &&
                 (FW'(buckets) > min_floor);
    if (grow_ok) begin
      new_buckets = buckets << 1;
    end else if (shrink_ok) begin
      new_buckets = buckets >> 1;
    end else begin
      new_buckets = buckets;
    end

    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_take) state_next = S_SEARCH;
      end
      S_SEARCH: begin
        if (search_end) begin
          if (op == OP_REMOVE && found_now) state_next = S_WRITE;
          else state_next = S_FINISH;
        end
      end
      S_WRITE:  state_next = S_FINISH;
      S_FINISH: begin
        if (finish_fire) state_next = S_IDLE;
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    mem_q <= store[rd_addr];
    if (mem_we) begin
      store[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid    <= 1'b0;
      count      <= '0;
      buckets    <= BW'(10);
      grow_pct   <= 7'd65;
      shrink_pct <= 7'd30;
      min_b      <= CFG_DATA_W'(10);
      out_valid  <= 1'b0;
      found      <= 1'b0;
      added      <= 1'b0;
      status     <= STATUS_OK;
    end else begin
      if (cfg_wr.valid) begin
        case (cfg_wr.index)
          CFG_GROW:   grow_pct   <= cfg_wr.data[6:0];
          CFG_SHRINK: shrink_pct <= cfg_wr.data[6:0];
          CFG_MIN: begin
            min_b <= cfg_wr.data;
            if (count == '0) buckets <= BW'(cfg_floor);
          end
          default: ;
        endcase
      end

      if (out_take && out_valid) begin
        out_valid <= 1'b0;
      end

      if (req_take) begin
        op     <= req_head.op;
        key_r  <= req_head.key;
        idx    <= '0;
        found  <= 1'b0;
        added  <= 1'b0;
        status <= STATUS_OK;
      end

      if (state == S_SEARCH) begin
        q_valid <= issue;
        if (issue) begin
          idx   <= idx + CW'(1);
          q_idx <= idx[AW-1:0];
        end
        if (hit) begin
          found <= 1'b1;
          pos   <= q_idx;
        end
        if (search_end) begin
          pos <= pos_now;
          if (op == OP_INSERT && !found_now) begin
            if (store_full) begin
              status <= STATUS_FULL;
            end else begin
              count <= count + CW'(1);
              added <= 1'b1;
            end
          end
        end
      end

      if (state == S_WRITE) begin
        count <= count - CW'(1);
      end

      if (finish_fire) begin
        buckets               <= new_buckets;
        out_valid             <= 1'b1;
        out_item.was_present  <= found;
        out_item.status       <= status;
        out_item.bucket_index <= BIDX_W'(div_rem);
        out_item.item_count   <= COUNT_W'(count);
        out_item.bucket_total <= TOTAL_W'(new_buckets);
      end
    end
  end

endmodule
